/* design/nearest_smaller_values_stack_core_defines.svh */
// Assertion macros shared by the nearest smaller values stack core.
`ifndef NEAREST_SMALLER_VALUES_STACK_CORE_DEFINES_SVH
`define NEAREST_SMALLER_VALUES_STACK_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication under an active-low reset.
`define NSV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication under an active-low reset.
`define NSV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define NSV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define NSV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* design/nsv_pkg.sv */
// Shared constants and controller/datapath types of the nearest smaller values core.
`timescale 1ns / 1ps
`default_nettype none
package nsv_pkg;

  localparam int MAX_LEN_DEF    = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int SAMPLE_W       = 32;
  localparam int POS_W          = 31;

  localparam logic ANS_LEFT  = 1'b0;
  localparam logic ANS_RIGHT = 1'b1;

  typedef struct packed {
    logic accept;       // latch the incoming request, read the top entry
    logic take_left;    // record the top entry as left neighbour
    logic pop;          // answer the top entry as right neighbour, drop it
    logic push_left;    // answer the current item, push it
    logic flush_start;  // read the bottom entry
    logic flush_emit;   // answer one remaining entry with no neighbour
  } nsv_cmd_t;

  typedef struct packed {
    logic have_entry;
    logic multi;
    logic top_gt;
    logic top_eq;
    logic block_end;
    logic flush_last;
    logic out_free;
  } nsv_status_t;

endpackage
`default_nettype wire

/* design/nsv_ifs.sv */
// Valid/ready channel interfaces for sample requests and answers.
`timescale 1ns / 1ps
`default_nettype none
interface nsv_in_if;
  logic                          valid;
  logic                          ready;
  logic [nsv_pkg::SAMPLE_W-1:0]  sample_value;
  logic                          final_item;

  modport source (output valid, output sample_value, output final_item, input ready);
  modport sink   (input valid, input sample_value, input final_item, output ready);
endinterface

interface nsv_out_if;
  logic                       valid;
  logic                       ready;
  logic                       answer_kind;
  logic [nsv_pkg::POS_W-1:0]  item_position;
  logic [nsv_pkg::POS_W-1:0]  neighbour_position;
  logic                       neighbour_found;
  logic                       run_end;

  modport source (output valid, output answer_kind, output item_position,
                  output neighbour_position, output neighbour_found, output run_end,
                  input ready);
  modport sink   (input valid, input answer_kind, input item_position,
                  input neighbour_position, input neighbour_found, input run_end,
                  output ready);
endinterface
`default_nettype wire

/* design/nsv_ctrl.sv */
// Controller state machine of the nearest smaller values core.
`timescale 1ns / 1ps
`default_nettype none
module nsv_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire nsv_pkg::nsv_status_t status,
  output nsv_pkg::nsv_cmd_t         cmd
);
  import nsv_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CMP    = 3'd1;
  localparam logic [2:0] S_LEFT   = 3'd2;
  localparam logic [2:0] S_FLUSH0 = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.have_entry ? S_CMP : S_LEFT;
        end
      end
      S_CMP: begin
        if (status.top_gt) begin
          if (status.out_free) begin
            cmd.pop   = 1'b1;
            state_nxt = status.multi ? S_CMP : S_LEFT;
          end
        end else if (status.top_eq) begin
          if (status.out_free) begin
            cmd.pop       = 1'b1;
            cmd.take_left = 1'b1;
            state_nxt     = S_LEFT;
          end
        end else begin
          cmd.take_left = 1'b1;
          state_nxt     = S_LEFT;
        end
      end
      S_LEFT: begin
        if (status.out_free) begin
          cmd.push_left = 1'b1;
          state_nxt     = status.block_end ? S_FLUSH0 : S_IDLE;
        end
      end
      S_FLUSH0: begin
        cmd.flush_start = 1'b1;
        state_nxt       = S_FLUSH;
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.flush_emit = 1'b1;
          state_nxt      = status.flush_last ? S_IDLE : S_FLUSH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/nsv_dpath.sv */
// Datapath of the nearest smaller values core: stack memory, counters, answer register.
`timescale 1ns / 1ps
`default_nettype none
module nsv_dpath #(
  parameter int MAX_LEN    = nsv_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = nsv_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [nsv_pkg::POS_W-1:0]    cfg_wr_data,
  input  wire logic [nsv_pkg::SAMPLE_W-1:0] in_sample_value,
  input  wire logic                         in_final_item,
  input  wire nsv_pkg::nsv_cmd_t            cmd,
  output nsv_pkg::nsv_status_t              status,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic                              out_answer_kind,
  output logic [nsv_pkg::POS_W-1:0]         out_item_position,
  output logic [nsv_pkg::POS_W-1:0]         out_neighbour_position,
  output logic                              out_neighbour_found,
  output logic                              out_run_end
);
  import nsv_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int HW = $clog2(MAX_LEN + 1);
  localparam int VW = (VALUE_BITS < SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
  localparam logic [AW:0] LAST_COUNT = (AW + 1)'(MAX_LEN - 1);

  logic [POS_W-1:0] base_r;
  logic [VW-1:0]    cur_val_r;
  logic             fin_r;
  logic [AW-1:0]    counter_r;
  logic [HW-1:0]    height_r;
  logic             left_found_r;
  logic [AW-1:0]    left_pos_r;
  logic [AW-1:0]    idx_r;

  logic [VW-1:0]    val_mem [MAX_LEN];
  logic [AW-1:0]    pos_mem [MAX_LEN];
  logic [VW-1:0]    rd_val_r;
  logic [AW-1:0]    rd_pos_r;

  logic             out_valid_r;
  logic             kind_r, found_r, run_end_r;
  logic [POS_W-1:0] item_pos_r, nb_pos_r;

  logic [HW-1:0]    height_m1, height_m2;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             out_free, out_load;
  logic             ld_kind, ld_found, ld_run_end;
  logic [AW-1:0]    ld_item, ld_nb;
  logic             block_end, flush_last;

  assign height_m1  = height_r - HW'(1);
  assign height_m2  = height_r - HW'(2);
  assign block_end  = fin_r || (({1'b0, counter_r} + (AW + 1)'(1)) >= LAST_COUNT);
  assign flush_last = (HW'(idx_r) == height_m1);
  assign out_free   = !out_valid_r || out_ready;
  assign out_load   = cmd.pop || cmd.push_left || cmd.flush_emit;

  assign status.have_entry = (height_r != '0);
  assign status.multi      = (height_r > HW'(1));
  assign status.top_gt     = $signed(rd_val_r) > $signed(cur_val_r);
  assign status.top_eq     = (rd_val_r == cur_val_r);
  assign status.block_end  = block_end;
  assign status.flush_last = flush_last;
  assign status.out_free   = out_free;

  // Stack read port: one address a cycle, data registered.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.accept) begin
      rd_en   = (height_r != '0);
      rd_addr = height_m1[AW-1:0];
    end else if (cmd.pop) begin
      rd_en   = (height_r > HW'(1));
      rd_addr = height_m2[AW-1:0];
    end else if (cmd.flush_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.flush_emit) begin
      rd_en   = !flush_last;
      rd_addr = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_left) begin
      val_mem[height_r[AW-1:0]] <= cur_val_r;
      pos_mem[height_r[AW-1:0]] <= counter_r;
    end
    if (rd_en) begin
      rd_val_r <= val_mem[rd_addr];
      rd_pos_r <= pos_mem[rd_addr];
    end
  end

  // Answer fields chosen by the issuing command.
  always_comb begin
    ld_kind    = ANS_RIGHT;
    ld_item    = rd_pos_r;
    ld_nb      = counter_r;
    ld_found   = 1'b1;
    ld_run_end = 1'b0;
    if (cmd.push_left) begin
      ld_kind    = ANS_LEFT;
      ld_item    = counter_r;
      ld_nb      = left_pos_r;
      ld_found   = left_found_r;
      ld_run_end = !block_end;
    end else if (cmd.flush_emit) begin
      ld_nb      = '0;
      ld_found   = 1'b0;
      ld_run_end = flush_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      counter_r   <= '0;
      height_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.pop) begin
        height_r <= height_m1;
      end else if (cmd.push_left) begin
        height_r  <= height_r + HW'(1);
        counter_r <= counter_r + AW'(1);
      end else if (cmd.flush_emit && flush_last) begin
        height_r  <= '0;
        counter_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_val_r    <= in_sample_value[VW-1:0];
      fin_r        <= in_final_item;
      left_found_r <= 1'b0;
    end else if (cmd.take_left) begin
      left_found_r <= 1'b1;
      left_pos_r   <= rd_pos_r;
    end
    if (cmd.flush_start) begin
      idx_r <= '0;
    end else if (cmd.flush_emit) begin
      idx_r <= idx_r + AW'(1);
    end
    if (out_load) begin
      kind_r     <= ld_kind;
      item_pos_r <= base_r + POS_W'(ld_item);
      nb_pos_r   <= ld_found ? (base_r + POS_W'(ld_nb)) : '0;
      found_r    <= ld_found;
      run_end_r  <= ld_run_end;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_answer_kind        = kind_r;
  assign out_item_position      = item_pos_r;
  assign out_neighbour_position = nb_pos_r;
  assign out_neighbour_found    = found_r;
  assign out_run_end            = run_end_r;

endmodule
`default_nettype wire

/* design/nearest_smaller_values_stack_core.sv */
// Top level of the nearest smaller values stack core.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_smaller_values_stack_core_defines.svh"
// All nearest smaller values over a stream of signed samples, in one forward
// pass. Each sample request pops every stacked earlier sample greater than
// itself (answering each with a right neighbour), pops an equal top entry the
// same way, then gets its own left-neighbour answer (nearest earlier sample
// less than or equal to it, or none) and is pushed. After a request flagged
// final_item, or after MAX_LEN-1 samples, the block ends: every entry still
// stacked gets a right answer of "none", bottom first, and positions restart
// at 0. All positions are offset by the index_base register (cfg_wr_data)
// modulo 2^31; the user must write it only while idle, the block does not
// enforce this. Timing: one request at a time. A request passes an accept
// step, a pop for each greater entry, one further step when an entry not
// greater than it stays on top (an equal top is popped in that same step),
// and a step for its own answer and push; a block end adds a flush-start
// step and an emit for each remaining entry. This sequence is set by the
// single read port of the stack memory and the one answer register. Every
// entry is popped or flushed once; a stalled output holds back the pops,
// answers and flush emits. The block accepts the next request while its
// last answer still waits in the output register.
module nearest_smaller_values_stack_core #(
  parameter int MAX_LEN    = nsv_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = nsv_pkg::VALUE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [nsv_pkg::POS_W-1:0] cfg_wr_data,
  nsv_in_if.sink                         in_chan,
  nsv_out_if.source                      out_chan
);
  import nsv_pkg::*;

  nsv_cmd_t    cmd;
  nsv_status_t status;

  // Sequencer: decides which stack step runs each cycle.
  nsv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Stack storage, position counters and the answer register.
  nsv_dpath #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_sample_value        (in_chan.sample_value),
    .in_final_item          (in_chan.final_item),
    .cmd                    (cmd),
    .status                 (status),
    .out_ready              (out_chan.ready),
    .out_valid              (out_chan.valid),
    .out_answer_kind        (out_chan.answer_kind),
    .out_item_position      (out_chan.item_position),
    .out_neighbour_position (out_chan.neighbour_position),
    .out_neighbour_found    (out_chan.neighbour_found),
    .out_run_end            (out_chan.run_end)
  );

  // A taken request keeps the input closed while its stack work runs.
  `NSV_ASSERT_NXT(a_busy_after_accept, clk, rst_n,
                  in_chan.valid && in_chan.ready, !in_chan.ready,
                  "input still open after a request was taken")
  // No answer is loaded over one that has not been taken.
  `NSV_ASSERT_IMP(a_emit_needs_room, clk, rst_n,
                  cmd.pop || cmd.push_left || cmd.flush_emit, status.out_free,
                  "answer register overwritten")
  // Pops only ever hit a non-empty stack.
  `NSV_ASSERT_IMP(a_pop_nonempty, clk, rst_n,
                  cmd.pop, status.have_entry,
                  "pop issued on an empty stack")

endmodule
`default_nettype wire

/* verif/tb_nearest_smaller_values_stack_core.sv */
// Testbench of the nearest smaller values stack core: random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_nearest_smaller_values_stack_core;
  import nsv_pkg::*;

  localparam int          BLOCK_CUT    = MAX_LEN_DEF - 1;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam logic [SAMPLE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [SAMPLE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  // One answer as it leaves the block.
  typedef struct packed {
    logic             answer_kind;
    logic [POS_W-1:0] item_position;
    logic [POS_W-1:0] neighbour_position;
    logic             neighbour_found;
    logic             run_end;
  } answer_t;

  // Tracks the stack of open samples and the answers still owed by the block.
  class neighbour_tracker;
    logic [4:0]                stack_pos [MAX_LEN_DEF];
    logic signed [SAMPLE_W-1:0] stack_val [MAX_LEN_DEF];
    int unsigned               depth = 0;
    int unsigned               next_index = 0;
    logic [POS_W-1:0]          base = '0;
    answer_t                   pending_answers [$];
    int unsigned               mismatches = 0;

    function void set_base(logic [POS_W-1:0] b);
      base = b;
    endfunction

    function void owe(logic kind, int unsigned idx, int unsigned nb, logic found);
      answer_t a;
      a.answer_kind        = kind;
      a.item_position      = POS_W'(base + idx);
      a.neighbour_position = found ? POS_W'(base + nb) : '0;
      a.neighbour_found    = found;
      a.run_end            = 1'b0;
      pending_answers.push_back(a);
    endfunction

    // Work out every answer that one accepted request causes.
    function void absorb_sample(logic signed [SAMPLE_W-1:0] value, logic fin);
      int unsigned idx;
      int unsigned left;
      logic        found;
      answer_t     last;
      idx = next_index;
      // Pop every greater entry, top first.
      while (depth > 0 && stack_val[depth-1] > value) begin
        owe(ANS_RIGHT, stack_pos[depth-1], idx, 1'b1);
        depth--;
      end
      found = (depth > 0);
      left  = found ? stack_pos[depth-1] : 0;
      // An equal entry on top is resolved by this sample as well.
      if (depth > 0 && stack_val[depth-1] == value) begin
        owe(ANS_RIGHT, stack_pos[depth-1], idx, 1'b1);
        depth--;
      end
      owe(ANS_LEFT, idx, left, found);
      stack_pos[depth] = 5'(idx);
      stack_val[depth] = value;
      depth++;
      next_index++;
      // Block end: flush the rest bottom first with no neighbour.
      if (fin || next_index >= BLOCK_CUT) begin
        for (int unsigned i = 0; i < depth; i++) owe(ANS_RIGHT, stack_pos[i], 0, 1'b0);
        depth      = 0;
        next_index = 0;
      end
      last = pending_answers.pop_back();
      last.run_end = 1'b1;
      pending_answers.push_back(last);
    endfunction

    function void check_answer(answer_t got);
      answer_t exp;
      if (pending_answers.size() == 0) begin
        $error("unexpected answer kind=%0d item=%0d", got.answer_kind, got.item_position);
        mismatches++;
        return;
      end
      exp = pending_answers.pop_front();
      if (got.answer_kind !== exp.answer_kind) begin
        $error("answer_kind expected %0d got %0d", exp.answer_kind, got.answer_kind);
        mismatches++;
      end
      if (got.item_position !== exp.item_position) begin
        $error("item_position expected %0d got %0d", exp.item_position, got.item_position);
        mismatches++;
      end
      if (got.neighbour_position !== exp.neighbour_position) begin
        $error("neighbour_position expected %0d got %0d",
               exp.neighbour_position, got.neighbour_position);
        mismatches++;
      end
      if (got.neighbour_found !== exp.neighbour_found) begin
        $error("neighbour_found expected %0d got %0d", exp.neighbour_found, got.neighbour_found);
        mismatches++;
      end
      if (got.run_end !== exp.run_end) begin
        $error("run_end expected %0d got %0d", exp.run_end, got.run_end);
        mismatches++;
      end
    endfunction

    function int unsigned owed();
      return pending_answers.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [POS_W-1:0] cfg_wr_data;
  logic             steady_source;
  logic             steady_sink;
  int unsigned      cycle_count;
  neighbour_tracker board;

  nsv_in_if  in_chan ();
  nsv_out_if out_chan ();

  nearest_smaller_values_stack_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: count every rising edge and bail out well past the slowest correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_nearest_smaller_values_stack_core NOT OK");
      $finish;
    end
  end

  // Note each accepted request; its answers go to the back of the queue.
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      board.absorb_sample(in_chan.sample_value, in_chan.final_item);
  end

  // Check each accepted answer against the oldest one owed.
  always @(posedge clk) begin
    answer_t seen;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen.answer_kind        = out_chan.answer_kind;
      seen.item_position      = out_chan.item_position;
      seen.neighbour_position = out_chan.neighbour_position;
      seen.neighbour_found    = out_chan.neighbour_found;
      seen.run_end            = out_chan.run_end;
      board.check_answer(seen);
    end
  end

  // Answer sink: randomly drop ready before each answer, never in steady stretches.
  initial begin
    int unsigned hold;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      hold = steady_sink ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Send one request: idle first, then hold valid until the block takes it.
  // Entered and left at a falling edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic fin);
    int unsigned gap;
    gap = steady_source ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.sample_value <= value;
    in_chan.final_item   <= fin;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Lower valid and wait until every owed answer has come back.
  task automatic drain_answers();
    in_chan.valid <= 1'b0;
    while (board.owed() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the base register; only called with the block idle.
  task automatic write_index_base(input logic [POS_W-1:0] b);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_base(b);
  endtask

  // Random sequences: mostly short blocks ended by final_item, some long enough
  // to hit the block cut, a few left open so they run into the next one.
  task automatic run_random_requests(input int unsigned total);
    int unsigned         sent;
    int unsigned         len;
    int unsigned         shape;
    logic [SAMPLE_W-1:0] v;
    logic                fin;
    sent = 0;
    while (sent < total) begin
      shape = $urandom_range(0, 7);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 12);
      steady_source = ($urandom_range(0, 4) == 0);
      steady_sink   = ($urandom_range(0, 4) == 0);
      v = (shape == 3) ? VAL_MIN + $urandom_range(0, 1000) : $urandom;
      for (int unsigned k = 0; k < len && sent < total; k++) begin
        case (shape)
          0, 1: v = $urandom_range(0, 6) - 3;       // tight range: many equal values
          2:    v = $urandom;                       // full range
          3:    v = v + $urandom_range(0, 3);       // rising: stack grows, big flush
          4:    v = v - $urandom_range(0, 3);       // falling: a pop on most samples
          5: begin
            case ($urandom_range(0, 3))
              0:       v = VAL_MIN;
              1:       v = VAL_MAX;
              2:       v = '1;
              default: v = '0;
            endcase
          end
          default: v = $urandom_range(0, 40);
        endcase
        if (k == len - 1) fin = ($urandom_range(0, 7) != 0);
        else              fin = ($urandom_range(0, 40) == 0);
        // Close the last block so the register can be rewritten safely.
        if (sent == total - 1) fin = 1'b1;
        send_sample(v, fin);
        sent++;
      end
    end
    steady_source = 1'b0;
    steady_sink   = 1'b0;
  endtask

  initial begin
    board = new();
    cycle_count          = 0;
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    steady_source        = 1'b0;
    steady_sink          = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.sample_value = '0;
    in_chan.final_item   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: a lone sample (no left neighbour, flushed at once), then the value
    // extremes with greater pops, an equal top, and an equal bottom at the end.
    send_sample(32'd0, 1'b1);
    send_sample(VAL_MIN, 1'b0);
    send_sample(-32'sd5, 1'b0);
    send_sample(32'd7, 1'b0);
    send_sample(VAL_MAX, 1'b0);
    send_sample(32'd7, 1'b0);        // pops the maximum, then the equal 7
    send_sample(-32'sd6, 1'b0);      // pops 7 and -5
    send_sample(VAL_MIN, 1'b0);      // pops -6, resolves the equal minimum
    send_sample(VAL_MAX, 1'b1);      // final: flush bottom first
    send_sample(32'hFFFF_FFFF, 1'b1);
    drain_answers();

    // Positions wrap modulo 2^31 with the base at its top.
    write_index_base('1);
    send_sample(32'd3, 1'b0);
    send_sample(32'd9, 1'b0);
    send_sample(32'd1, 1'b1);
    run_random_requests(90);
    drain_answers();

    // Base just under the top so the wrap falls inside a block.
    write_index_base(31'h7FFF_FFE5);
    run_random_requests(90);
    drain_answers();

    write_index_base(POS_W'($urandom));
    run_random_requests(90);
    drain_answers();

    write_index_base('0);
    run_random_requests(90);
    drain_answers();

    // Give any stray answer time to show up.
    repeat (40) @(negedge clk);

    if (board.mismatches == 0 && board.owed() == 0) begin
      $display("tb_nearest_smaller_values_stack_core OK");
    end else begin
      $display("tb_nearest_smaller_values_stack_core NOT OK");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/nsv_pkg.sv
design/nsv_ifs.sv
design/nsv_ctrl.sv
design/nsv_dpath.sv
design/nearest_smaller_values_stack_core.sv
verif/tb_nearest_smaller_values_stack_core.sv
